>>> rtl/improved_perlin_noise_3d_defines.svh
// Assertion helpers shared by the noise block.
`ifndef IMPROVED_PERLIN_NOISE_3D_DEFINES_SVH
`define IMPROVED_PERLIN_NOISE_3D_DEFINES_SVH

// Checks that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_NOW(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/ipn_pkg.sv
package ipn_pkg;
   localparam int TABLE_SIZE_DEF = 256;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int COORD_W        = 48;
   localparam int OFFSET_W       = 24;
   localparam int OUT_W          = 18;
   localparam int HASH_W         = 8;
   localparam int CFG_IDX_W      = 2;
   localparam int OUT_MAX        = 131071;
   localparam int OUT_MIN        = -131072;

   localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd0;
   localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd1;
   localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 2'd2;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_EVAL = 1'b1;
endpackage

>>> rtl/improved_perlin_noise_3d.sv
// Improved 3D gradient noise, one point per cycle.
// req channel: kind in tuser; tdata holds, lowest bit up, table_index[7:0],
// table_value[7:0], coord_x[47:0], coord_y[47:0], coord_z[47:0] (160 bits).
// A load word (kind 0) writes one permutation table entry and gives no
// result; the table must be loaded before any evaluate word (kind 1).
// rsp channel: tdata holds noise_value[17:0], signed Q1.16, in 24 bits.
// csr channel writes offset_x, offset_y, offset_z at indexes 0 to 2; it is
// always ready and should only be written while no word is in flight.
// The pipeline is a chain of register stages sharing one enable. An evaluate
// word's valid bit travels with it down a register chain to rsp_tvalid.
// Throughput is one word per cycle: the three hash levels read
// fourteen replicated copies of the table (2, 4 and 8) in parallel, so each
// level is one memory read stage. A load word reaches each level's copies at
// that level's read time, so words keep their order against the table.
// While the receiver stalls with a result waiting, the whole pipeline holds;
// req_tready is high whenever the result register is empty or being taken.
// Reset clears valid bits and offsets only; the table contents are undefined
// until written.
module improved_perlin_noise_3d #(
   parameter int TABLE_SIZE = ipn_pkg::TABLE_SIZE_DEF,
   parameter int FRAC_BITS  = ipn_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [159:0]                   req_tdata,   // index, value, x, y, z
   input  logic                           req_tuser,   // kind
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [23:0]                    rsp_tdata,   // noise_value
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ipn_pkg::CFG_IDX_W-1:0]  csr_index,
   input  logic [ipn_pkg::OFFSET_W-1:0]   csr_data
);
   import ipn_pkg::*;
   `include "improved_perlin_noise_3d_defines.svh"

   localparam int AW  = $clog2(TABLE_SIZE);
   localparam int FB  = FRAC_BITS;
   localparam int VW  = FB + 4;   // gradient and blend values stay within +-4
   localparam int LAT = 10;

   // Stall control: single enable for the whole pipeline.
   logic en;
   logic [LAT-1:0] vld_ff;
   logic out_vld_ff;
   logic [OUT_W-1:0] out_ff;
   assign en         = !out_vld_ff || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   logic [OFFSET_W-1:0] offx_ff, offy_ff, offz_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         offx_ff <= '0; offy_ff <= '0; offz_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_OFFSET_X: offx_ff <= csr_data;
            REG_OFFSET_Y: offy_ff <= csr_data;
            REG_OFFSET_Z: offz_ff <= csr_data;
            default: ;
         endcase
      end
   end

   wire acc = req_tvalid && en;
   wire load = acc && (req_tuser == KIND_LOAD);
   wire eval = acc && (req_tuser == KIND_EVAL);

   // Load words travel down their own short pipe. The first level's copies
   // are written at acceptance, the second level's from pipe register 1 and
   // the third level's from pipe register 3, which matches when each level
   // reads for an evaluate word.
   logic [3:0]    ld_vld_ff;
   logic [AW-1:0] ld_idx_ff [4];
   logic [7:0]    ld_val_ff [4];
   always_ff @(posedge clock) begin
      if (reset) begin
         ld_vld_ff <= '0;
      end else if (en) begin
         ld_vld_ff <= {ld_vld_ff[2:0], load};
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         ld_idx_ff[0] <= req_tdata[AW-1:0];
         ld_val_ff[0] <= req_tdata[15:8];
         for (int i = 1; i < 4; i++) begin
            ld_idx_ff[i] <= ld_idx_ff[i-1];
            ld_val_ff[i] <= ld_val_ff[i-1];
         end
      end
   end

   // Stage 0: add offsets.
   logic signed [COORD_W:0] sx_ff, sy_ff, sz_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         sx_ff <= $signed({req_tdata[63:16], 1'b0}) / 2 + $signed({1'b0, offx_ff});
         sy_ff <= $signed({req_tdata[111:64], 1'b0}) / 2 + $signed({1'b0, offy_ff});
         sz_ff <= $signed({req_tdata[159:112], 1'b0}) / 2 + $signed({1'b0, offz_ff});
      end
   end

   logic [AW-1:0] xi, yi, zi;
   logic [FB-1:0] fx, fy, fz;
   assign xi = sx_ff[FB +: AW]; assign yi = sy_ff[FB +: AW]; assign zi = sz_ff[FB +: AW];
   assign fx = sx_ff[FB-1:0];   assign fy = sy_ff[FB-1:0];   assign fz = sz_ff[FB-1:0];

   // Fades run alongside the hash levels.
   logic [FB:0] u, v, w;
   ipn_fade #(.FRAC_BITS(FB)) u_fu (.clock, .en, .frac(fx), .fade_out(u));
   ipn_fade #(.FRAC_BITS(FB)) u_fv (.clock, .en, .frac(fy), .fade_out(v));
   ipn_fade #(.FRAC_BITS(FB)) u_fw (.clock, .en, .frac(fz), .fade_out(w));

   // Fraction and integer delay line.
   logic [FB-1:0] fx_d [5], fy_d [5], fz_d [5];
   logic [AW-1:0] y_d, z_d [3];
   always_ff @(posedge clock) begin
      if (en) begin
         fx_d[0] <= fx; fy_d[0] <= fy; fz_d[0] <= fz;
         y_d <= yi; z_d[0] <= zi;
         for (int i = 1; i < 5; i++) begin
            fx_d[i] <= fx_d[i-1]; fy_d[i] <= fy_d[i-1]; fz_d[i] <= fz_d[i-1];
         end
         for (int i = 1; i < 3; i++) z_d[i] <= z_d[i-1];
      end
   end

   // Hash levels: 2 reads, 4 reads, 8 reads; every copy gets every load.
   logic [AW-1:0] l1a [2], l2a [4], l3a [8];
   logic [7:0]    l1d [2], l2d [4], l3d [8];
   assign l1a[0] = xi; assign l1a[1] = xi + 1'b1;
   genvar g;
   generate
      for (g = 0; g < 14; g++) begin : g_tab
         logic [AW-1:0] ra;
         logic [7:0] rd;
         logic we;
         logic [AW-1:0] wa;
         logic [7:0] wd;
         if (g < 2) begin : g1
            assign ra = l1a[g]; assign l1d[g] = rd;
            assign we = load;
            assign wa = req_tdata[AW-1:0];
            assign wd = req_tdata[15:8];
         end else if (g < 6) begin : g2
            assign ra = l2a[g-2]; assign l2d[g-2] = rd;
            assign we = en && ld_vld_ff[1];
            assign wa = ld_idx_ff[1];
            assign wd = ld_val_ff[1];
         end else begin : g3
            assign ra = l3a[g-6]; assign l3d[g-6] = rd;
            assign we = en && ld_vld_ff[3];
            assign wa = ld_idx_ff[3];
            assign wd = ld_val_ff[3];
         end
         ipn_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram (
            .clock, .wr_en(we), .wr_addr(wa),
            .wr_data(wd), .rd_en(en), .rd_addr(ra), .rd_data(rd));
      end
   endgenerate

   // Level 2 address: A, A+1, B, B+1 (after registering sums).
   logic [AW-1:0] ab_ff [2];
   logic [AW-1:0] h2_ff [4];
   always_ff @(posedge clock) begin
      if (en) begin
         ab_ff[0] <= AW'(l1d[0]) + y_d;
         ab_ff[1] <= AW'(l1d[1]) + y_d;
         for (int i = 0; i < 4; i++) h2_ff[i] <= AW'(l2d[i]) + z_d[2];
      end
   end
   assign l2a[0] = ab_ff[0]; assign l2a[1] = ab_ff[0] + 1'b1;
   assign l2a[2] = ab_ff[1]; assign l2a[3] = ab_ff[1] + 1'b1;
   // Order: AA, AB, BA, BB; each with +0 and +1.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         l3a[2*i]   = h2_ff[i];
         l3a[2*i+1] = h2_ff[i] + 1'b1;
      end
   end
   // Timing: stage0 regs s*, RAM1 at stage1, ab at 2, RAM2 at 3, h2 at 4, RAM3 at 5.
   // Fractions used for the gradients at stage 6 are fx_d[4]. The fades leave
   // their units at stage 3 and are delayed below to meet each blend level.

   function automatic logic signed [VW-1:0] grad(input logic [3:0] h,
         input logic signed [VW-1:0] x, input logic signed [VW-1:0] y,
         input logic signed [VW-1:0] z);
      logic signed [VW-1:0] a, b;
      a = (h < 8) ? x : y;
      b = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
      return (h[0] ? -a : a) + (h[1] ? -b : b);
   endfunction

   localparam logic signed [VW-1:0] ONEV = VW'(1) <<< FB;
   logic signed [VW-1:0] g_in [8];
   logic signed [VW-1:0] g_ff [8];
   logic [FB:0] u_d [3], v_d [4], w_d [5];
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         g_in[i] = grad(l3d[i][3:0],
                        $signed({4'b0, fx_d[4]}) - (((i & 4) != 0) ? ONEV : '0),
                        $signed({4'b0, fy_d[4]}) - (((i & 2) != 0) ? ONEV : '0),
                        $signed({4'b0, fz_d[4]}) - (((i & 1) != 0) ? ONEV : '0));
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 8; i++) g_ff[i] <= g_in[i];
         u_d[0] <= u; v_d[0] <= v; w_d[0] <= w;
         for (int i = 1; i < 3; i++) u_d[i] <= u_d[i-1];
         for (int i = 1; i < 4; i++) v_d[i] <= v_d[i-1];
         for (int i = 1; i < 5; i++) w_d[i] <= w_d[i-1];
      end
   end

   function automatic logic signed [VW-1:0] lerp(input logic [FB:0] t,
         input logic signed [VW-1:0] a, input logic signed [VW-1:0] b);
      logic signed [VW+FB+2:0] p;
      p = $signed({1'b0, t}) * (b - a);
      return a + VW'(p >>> FB);
   endfunction

   // g_ff index bits: [2]=x, [1]=y, [0]=z. The x blend uses u_d[2], the y
   // blend, in the register after it, v_d[3], and the z blend w_d[4].
   logic signed [VW-1:0] lx_ff [4], ly_ff [2], lz_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) lx_ff[i] <= lerp(u_d[2], g_ff[i], g_ff[i+4]);
         ly_ff[0] <= lerp(v_d[3], lx_ff[0], lx_ff[2]);
         ly_ff[1] <= lerp(v_d[3], lx_ff[1], lx_ff[3]);
         lz_ff    <= lerp(w_d[4], ly_ff[0], ly_ff[1]);
      end
   end

   logic signed [VW+8:0] r;
   always_comb begin
      if (FB >= 16) r = (VW+9)'(lz_ff >>> (FB - 16));
      else          r = (VW+9)'(lz_ff) <<< (16 - FB);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0; out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], eval};
         out_vld_ff <= vld_ff[LAT-1];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         if (r > OUT_MAX)      out_ff <= OUT_W'(OUT_MAX);
         else if (r < OUT_MIN) out_ff <= OUT_W'(OUT_MIN);
         else                  out_ff <= OUT_W'(r);
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(24-OUT_W){1'b0}}, out_ff};

   `ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `ASSERT_NOW(a_ready, clock, reset, !rsp_tvalid, req_tready)
   `ASSERT_NEXT(a_load_quiet, clock, reset, load && !out_vld_ff, !vld_ff[0])
endmodule

>>> rtl/ipn_ram.sv
module ipn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/ipn_math.sv
// Small fixed point helpers: fade polynomial stage and lerp/grad done inline by caller.
module ipn_fade #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [FRAC_BITS-1:0] frac,
   output logic [FRAC_BITS:0]   fade_out
);
   // Three register steps: t*t and (6t-15)*t, then t2*t, then t3*b.
   localparam int W = FRAC_BITS + 6;
   localparam logic signed [W+1:0] ONE = (W+2)'(1) <<< FRAC_BITS;

   logic [FRAC_BITS-1:0]   t_ff;
   logic [FRAC_BITS-1:0]   t2_ff;
   logic signed [W+1:0]    b_ff, b2_ff;
   logic [FRAC_BITS-1:0]   t3_ff;
   logic [FRAC_BITS:0]     f_ff;

   logic signed [W+1:0]             a;
   logic signed [FRAC_BITS+W+2:0]   ta;
   logic [2*FRAC_BITS-1:0]          sq, cu;
   logic signed [FRAC_BITS+W+2:0]   fb;

   always_comb begin
      a  = (W+2)'(6 * $signed({2'b0, (W)'(frac)}) - 15 * ONE);
      ta = $signed({1'b0, frac}) * a;
      sq = frac * frac;
      cu = t2_ff * t_ff;
      fb = $signed({1'b0, t3_ff}) * b2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff    <= frac;
         t2_ff   <= sq[2*FRAC_BITS-1:FRAC_BITS];
         b_ff    <= (W+2)'((ta >>> FRAC_BITS) + 10 * ONE);
         t3_ff   <= cu[2*FRAC_BITS-1:FRAC_BITS];
         b2_ff   <= b_ff;
         f_ff    <= (FRAC_BITS+1)'(fb >>> FRAC_BITS);
      end
   end

   assign fade_out = f_ff;
endmodule
